FILE: hdl/sha256mh_pkg.sv
// ============================================================================
// sha256mh_pkg
// Shared types, constants and round functions of the SHA-256 message hasher.
// ============================================================================
package sha256mh_pkg;

    localparam int WORD_W    = 32;
    localparam int LEN_W     = 64;
    localparam int NUM_ROUND = 64;
    localparam int BLK_WORDS = 16;
    localparam int NUM_CHAIN = 8;

    localparam logic [WORD_W-1:0] PAD_WORD = 32'h8000_0000;
    localparam logic [3:0]        LEN_SLOT = 4'd14;

    // One word request toward the compression side.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              msg_end;
    } word_cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PAD80,
        F_ZEROS,
        F_LEN_HI,
        F_LEN_LO
    } front_state_t;

    typedef enum logic [1:0] {
        B_COLLECT,
        B_ROUNDS,
        B_UPDATE,
        B_OUTPUT
    } back_state_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [WORD_W-1:0] init_hash(input logic [2:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        init_hash = v;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [5:0] r);
        logic [WORD_W-1:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        round_k = k;
    endfunction

endpackage

FILE: hdl/sha256_message_hasher.sv
// Sequence: once the compression side takes the length word, it runs the 64
//   rounds, one per cycle, and one fold before the first digest word is valid.
// Blocks: each 64-byte block is gathered as 16 words and then compressed by
//   the single shared round unit, which takes no new word until it has folded
//   the block; each message then streams out its eight digest words.
// Reset: rst_n (async, active low) restores the initial hash values, clears
//   the bit count, word count, queue and all handshake state.
// ============================================================================
// sha256_message_hasher
// SHA-256 digest of one message received as big-endian 32-bit words, with
// eight digest words returned per message.
// ============================================================================
module sha256_message_hasher (
    input  logic        clk,
    input  logic        rst_n,
    // Input request channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] message_word,
    input  logic [2:0]  valid_bytes,
    input  logic        final_word,
    // Digest channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    // Word requests leave the front (message words plus generated padding)
    // and wait in the queue while the back is busy with its rounds.
    sha256mh_pkg::word_cmd_t front_cmd, back_cmd;
    logic                    front_valid, front_ready;
    logic                    back_valid, back_ready;

    // Front: count bits, mask the final word, generate padding and length.
    sha256mh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .final_word   (final_word),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    // Queue: decouple the front from the compression loop.
    sha256mh_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_cmd   (back_cmd)
    );

    // Back: gather blocks, compress, and hold each digest word until taken.
    sha256mh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (back_valid),
        .cmd_ready    (back_ready),
        .cmd          (back_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .digest_last  (digest_last)
    );

endmodule

FILE: hdl/sha256mh_front.sv
// ============================================================================
// sha256mh_front
// Accepts message words, counts message bits and expands the final word into
// the padded word stream (0x80 marker, zero fill, 64-bit length).
// ============================================================================
module sha256mh_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   message_word,
    input  logic [2:0]                    valid_bytes,
    input  logic                          final_word,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output sha256mh_pkg::word_cmd_t       cmd
);

    sha256mh_pkg::front_state_t state_reg, state_next;
    logic [sha256mh_pkg::LEN_W-1:0] len_reg, len_next;
    logic [3:0]                     fill_reg, fill_next;
    logic [2:0]                     nvalid;
    logic [31:0]                    keep_mask;
    logic [31:0]                    pad_bit;

    // Saturate byte count to one full word.
    always_comb
    begin
        nvalid = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nvalid)
            3'd1:    begin keep_mask = 32'hff00_0000; pad_bit = 32'h0080_0000; end
            3'd2:    begin keep_mask = 32'hffff_0000; pad_bit = 32'h0000_8000; end
            3'd3:    begin keep_mask = 32'hffff_ff00; pad_bit = 32'h0000_0080; end
            default: begin keep_mask = 32'h0000_0000; pad_bit = 32'h8000_0000; end
        endcase
    end

    assign in_ready = (state_reg == sha256mh_pkg::F_IDLE) && cmd_ready;

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        cmd_valid   = 1'b0;
        cmd.word    = '0;
        cmd.msg_end = 1'b0;
        unique case (state_reg)
            sha256mh_pkg::F_IDLE:
            begin
                cmd_valid = in_valid;
                if (!final_word)
                begin
                    cmd.word = message_word;
                    if (in_valid && cmd_ready)
                        len_next = len_reg + 64'd32;
                end
                else if (nvalid == 3'd4)
                begin
                    cmd.word = message_word;
                    if (in_valid && cmd_ready)
                    begin
                        len_next   = len_reg + 64'd32;
                        state_next = sha256mh_pkg::F_PAD80;
                    end
                end
                else
                begin
                    cmd.word = (message_word & keep_mask) | pad_bit;
                    if (in_valid && cmd_ready)
                    begin
                        len_next   = len_reg + {58'd0, nvalid, 3'd0};
                        state_next = sha256mh_pkg::F_ZEROS;
                    end
                end
            end
            sha256mh_pkg::F_PAD80:
            begin
                cmd_valid = 1'b1;
                cmd.word  = sha256mh_pkg::PAD_WORD;
                if (cmd_ready)
                    state_next = sha256mh_pkg::F_ZEROS;
            end
            sha256mh_pkg::F_ZEROS:
            begin
                // Zero fill up to the length slot.
                if (fill_reg == sha256mh_pkg::LEN_SLOT)
                    state_next = sha256mh_pkg::F_LEN_HI;
                else
                    cmd_valid = 1'b1;
            end
            sha256mh_pkg::F_LEN_HI:
            begin
                cmd_valid = 1'b1;
                cmd.word  = len_reg[63:32];
                if (cmd_ready)
                    state_next = sha256mh_pkg::F_LEN_LO;
            end
            sha256mh_pkg::F_LEN_LO:
            begin
                cmd_valid   = 1'b1;
                cmd.word    = len_reg[31:0];
                cmd.msg_end = 1'b1;
                if (cmd_ready)
                begin
                    len_next   = '0;
                    state_next = sha256mh_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = sha256mh_pkg::F_IDLE;
            end
        endcase
        fill_next = (cmd_valid && cmd_ready) ? fill_reg + 4'd1 : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256mh_pkg::F_IDLE;
            len_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

FILE: hdl/sha256mh_queue.sv
// ============================================================================
// sha256mh_queue
// Two-entry word request queue between the front and the compression side.
// ============================================================================
module sha256mh_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  sha256mh_pkg::word_cmd_t wr_cmd,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output sha256mh_pkg::word_cmd_t rd_cmd
);

    sha256mh_pkg::word_cmd_t slot_reg [2];
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic [1:0]              count_reg;
    logic                    push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

FILE: hdl/sha256mh_back.sv
// ============================================================================
// sha256mh_back
// Gathers 16 words into the schedule window, runs 64 rounds one per cycle,
// folds the result into the chain and streams out the digest.
// ============================================================================
module sha256mh_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  sha256mh_pkg::word_cmd_t       cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   digest_word,
    output logic [2:0]                    digest_index,
    output logic                          digest_last
);

    sha256mh_pkg::back_state_t state_reg, state_next;
    logic [31:0] w_reg     [16];
    logic [31:0] w_next    [16];
    logic [31:0] var_reg   [8];
    logic [31:0] var_next  [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next[8];
    logic [3:0]  count_reg, count_next;
    logic [5:0]  round_reg, round_next;
    logic [2:0]  idx_reg, idx_next;
    logic        end_reg, end_next;
    logic [31:0] t1, t2, sched_new, ch, maj;

    always_comb
    begin
        ch  = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
            ^ (var_reg[1] & var_reg[2]);
        t1  = var_reg[7] + sha256mh_pkg::big_sigma1(var_reg[4]) + ch
            + sha256mh_pkg::round_k(round_reg) + w_reg[0];
        t2  = sha256mh_pkg::big_sigma0(var_reg[0]) + maj;
        sched_new = sha256mh_pkg::small_sigma1(w_reg[14]) + w_reg[9]
                  + sha256mh_pkg::small_sigma0(w_reg[1]) + w_reg[0];
    end

    assign out_valid    = (state_reg == sha256mh_pkg::B_OUTPUT);
    assign digest_word  = chain_reg[idx_reg];
    assign digest_index = idx_reg;
    assign digest_last  = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        round_next = round_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        cmd_ready  = 1'b0;
        for (int i = 0; i < 16; i++)
            w_next[i] = w_reg[i];
        for (int i = 0; i < 8; i++)
        begin
            var_next[i]   = var_reg[i];
            chain_next[i] = chain_reg[i];
        end
        unique case (state_reg)
            sha256mh_pkg::B_COLLECT:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    for (int i = 0; i < 15; i++)
                        w_next[i] = w_reg[i+1];
                    w_next[15] = cmd.word;
                    count_next = count_reg + 4'd1;
                    if (count_reg == 4'd15)
                    begin
                        end_next   = cmd.msg_end;
                        round_next = '0;
                        for (int i = 0; i < 8; i++)
                            var_next[i] = chain_reg[i];
                        state_next = sha256mh_pkg::B_ROUNDS;
                    end
                end
            end
            sha256mh_pkg::B_ROUNDS:
            begin
                // Advance the schedule window and the working variables.
                for (int i = 0; i < 15; i++)
                    w_next[i] = w_reg[i+1];
                w_next[15]  = sched_new;
                var_next[7] = var_reg[6];
                var_next[6] = var_reg[5];
                var_next[5] = var_reg[4];
                var_next[4] = var_reg[3] + t1;
                var_next[3] = var_reg[2];
                var_next[2] = var_reg[1];
                var_next[1] = var_reg[0];
                var_next[0] = t1 + t2;
                round_next  = round_reg + 6'd1;
                if (round_reg == 6'(sha256mh_pkg::NUM_ROUND - 1))
                    state_next = sha256mh_pkg::B_UPDATE;
            end
            sha256mh_pkg::B_UPDATE:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] + var_reg[i];
                idx_next   = '0;
                state_next = end_reg ? sha256mh_pkg::B_OUTPUT : sha256mh_pkg::B_COLLECT;
            end
            sha256mh_pkg::B_OUTPUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            chain_next[i] = sha256mh_pkg::init_hash(3'(i));
                        state_next = sha256mh_pkg::B_COLLECT;
                    end
                end
            end
            default:
            begin
                state_next = sha256mh_pkg::B_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha256mh_pkg::B_COLLECT;
            count_reg <= '0;
            round_reg <= '0;
            idx_reg   <= '0;
            end_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha256mh_pkg::init_hash(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            round_reg <= round_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= chain_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
            w_reg[i] <= w_next[i];
        for (int i = 0; i < 8; i++)
            var_reg[i] <= var_next[i];
    end

endmodule

FILE: tb/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for the SHA-256 message hasher: messages in, digests out.
// Every accepted request feeds a behavioral SHA-256 model. The model builds the
// eight expected digest words of each message, and each digest word that the
// block returns is checked field by field against the oldest one still waiting.
// The run starts with a short table of directed requests. Known digests are
// typed in for the empty message and for "abc". Random messages follow, with
// extra weight on lengths that push the length field into an extra block.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 420;
    localparam int QUIET_AFTER     = 360;   // no idling from here to the end
    localparam int TAIL_CYCLES     = 200;   // watch for stray digest words after the drain
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles without any handshake
    localparam int PRINT_LIMIT     = 40;
    localparam int DIRECTED_ROWS   = 12;

    // Initial chaining value and round constants, packed first word in the MSBs.
    localparam logic [255:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam logic [2047:0] SHA_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] PAD_MARK = 32'h8000_0000;
    localparam int          LEN_SLOT = 14;

    // Well-known digests, used as typed expectations in the directed table.
    localparam logic [255:0] DIGEST_EMPTY =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] DIGEST_ABC =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    typedef struct packed {
        logic [31:0]  word;
        logic [2:0]   nbytes;
        logic         is_last;
        logic         typed;     // 1: digest below is the expectation
        logic [255:0] digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        is_last;
    } digest_beat_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        final_word;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    // Model state: chaining words, block buffer, fill count and message bit count.
    logic [31:0] chain_words [8];
    logic [31:0] block_words [16];
    int unsigned block_fill;
    logic [63:0] msg_bits;

    digest_beat_t expected_digest_q [$];
    int           fail_count;
    int           quiet_cycles;
    bit           idle_enable;
    int           out_stall_left;

    // Directed table: boundaries of valid_bytes, saturation, trailing byte drop,
    // a final word with no valid bytes after a non-empty message, and two
    // standard test vectors.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 3'd0, 1'b1, 1'b1, DIGEST_EMPTY},
        '{32'h6162_6300, 3'd3, 1'b1, 1'b1, DIGEST_ABC},
        '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, 256'h0},
        '{32'hffff_ffff, 3'd7, 1'b1, 1'b0, 256'h0},
        '{32'h0000_0000, 3'd5, 1'b1, 1'b0, 256'h0},
        '{32'ha5a5_a5a5, 3'd2, 1'b1, 1'b0, 256'h0},
        '{32'hffff_ffff, 3'd1, 1'b1, 1'b0, 256'h0},
        '{32'hdead_beef, 3'd3, 1'b0, 1'b0, 256'h0},
        '{32'h1234_5678, 3'd0, 1'b1, 1'b0, 256'h0},
        '{32'h0000_0000, 3'd7, 1'b0, 1'b0, 256'h0},
        '{32'hffff_ffff, 3'd6, 1'b0, 1'b0, 256'h0},
        '{32'h8000_0000, 3'd4, 1'b1, 1'b0, 256'h0}
    };

    sha256_message_hasher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .message_word (message_word),
        .valid_bytes  (valid_bytes),
        .final_word   (final_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .digest_index (digest_index),
        .digest_last  (digest_last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Return the model to the start of a message.
    task automatic restart_message();
        int i;
        for (i = 0; i < 8; i++)
            chain_words[i] = SHA_IV[255 - 32*i -: 32];
        block_fill = 0;
        msg_bits   = '0;
    endtask

    // Run the 64 rounds on the buffered block and fold into the chaining words.
    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        int r;
        for (r = 0; r < 16; r++)
            sched[r] = block_words[r];
        for (r = 16; r < 64; r++)
        begin
            s0 = ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3);
            s1 = ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10);
            sched[r] = s1 + sched[r-7] + s0 + sched[r-16];
        end
        a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
        e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
        for (r = 0; r < 64; r++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[2047 - 32*r -: 32] + sched[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endtask

    task automatic absorb_word(input logic [31:0] w);
        block_words[block_fill] = w;
        block_fill++;
        if (block_fill == 16)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // Advance the model by one request. On the final word apply the padding and
    // hand back the digest.
    task automatic hash_request(input logic [31:0] w, input logic [2:0] nb, input logic fin,
                                output bit done, output logic [255:0] digest);
        int unsigned nbytes;
        logic [31:0] keep;
        done   = 1'b0;
        digest = '0;
        if (!fin)
        begin
            // Non-final words always count as four bytes.
            msg_bits += 64'd32;
            absorb_word(w);
        end
        else
        begin
            nbytes = (nb > 3'd4) ? 4 : nb;
            msg_bits += 64'(8 * nbytes);
            if (nbytes == 4)
            begin
                absorb_word(w);
                absorb_word(PAD_MARK);
            end
            else
            begin
                // Drop the invalid trailing bytes and put the pad marker after the last one.
                keep = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8*nbytes));
                absorb_word((w & keep) | (32'h80 << (24 - 8*nbytes)));
            end
            while (block_fill != LEN_SLOT)
                absorb_word(32'h0);
            absorb_word(msg_bits[63:32]);
            absorb_word(msg_bits[31:0]);
            for (int i = 0; i < 8; i++)
                digest[255 - 32*i -: 32] = chain_words[i];
            done = 1'b1;
            restart_message();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Present one request, hold it until accepted, then feed the model. Rows
    // with a typed digest use it as the expectation instead of the model's.
    task automatic send_request(input logic [31:0] w, input logic [2:0] nb, input logic fin,
                                input logic typed, input logic [255:0] typed_digest);
        int gap;
        bit done;
        logic [255:0] digest;
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= w;
        valid_bytes  <= nb;
        final_word   <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_request(w, nb, fin, done, digest);
        if (done)
        begin
            if (typed)
                digest = typed_digest;
            for (int i = 0; i < 8; i++)
                expected_digest_q.push_back('{digest[255 - 32*i -: 32], 3'(i), (i == 7)});
        end
    endtask

    // Digest side: stall in random bursts, always ready once idling stops.
    initial
    begin
        out_ready      <= 1'b0;
        out_stall_left  = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (out_stall_left > 0)
            begin
                out_stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                out_stall_left = $urandom_range(1, 10) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Check every accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_digest_q.size() == 0)
                report_mismatch("unexpected digest word", digest_word, 32'h0);
            else
            begin
                want = expected_digest_q.pop_front();
                if (digest_word !== want.word)
                    report_mismatch("digest_word", digest_word, want.word);
                if (digest_index !== want.pos)
                    report_mismatch("digest_index", 32'(digest_index), 32'(want.pos));
                if (digest_last !== want.is_last)
                    report_mismatch("digest_last", 32'(digest_last), 32'(want.is_last));
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int row;
        int len;
        int k;
        int sent;
        logic [2:0] nb;

        // Drive every input to a known value and hold reset.
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        message_word <= '0;
        valid_bytes  <= '0;
        final_word   <= 1'b0;
        fail_count    = 0;
        quiet_cycles  = 0;
        idle_enable   = 1'b1;
        restart_message();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        for (row = 0; row < DIRECTED_ROWS; row++)
            send_request(directed_rows[row].word, directed_rows[row].nbytes,
                         directed_rows[row].is_last, directed_rows[row].typed,
                         directed_rows[row].digest);
        sent = DIRECTED_ROWS;

        // Random messages. Lengths 13 to 17 and 29 to 32 words cover the cases where the
        // padding spills into one more block; most messages stay short to keep the run fast.
        while (sent < TARGET_REQUESTS)
        begin
            if (sent >= QUIET_AFTER)
                idle_enable = 1'b0;
            case ($urandom_range(0, 7))
                0:       len = $urandom_range(13, 17);
                1:       len = $urandom_range(29, 32);
                2:       len = $urandom_range(18, 48);
                default: len = $urandom_range(1, 12);
            endcase
            // Trim the last message so the run ends at the request target.
            if (len > TARGET_REQUESTS - sent)
                len = TARGET_REQUESTS - sent;
            for (k = 0; k < len - 1; k++)
            begin
                send_request($urandom, 3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
                sent++;
            end
            // Mostly a regular byte count on the final word; sometimes none, or
            // an over-range count that must saturate to four.
            case ($urandom_range(0, 9))
                0:       nb = 3'd0;
                1:       nb = 3'($urandom_range(5, 7));
                default: nb = 3'($urandom_range(1, 4));
            endcase
            send_request($urandom, nb, 1'b1, 1'b0, '0);
            sent++;
        end
        in_valid <= 1'b0;

        // Drain the digests still owed, then watch a while for stray words.
        while (expected_digest_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
